### sv/mfde_pkg.sv
// ----------------------------------------------------------------------------
// mfde_pkg: shared types and constants of the framebuffer draw engine
// Command codes, controller states and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package mfde_pkg;

    // Field widths of one input transaction (fixed by the stream format).
    localparam int XW   = 7;   // column field
    localparam int YW   = 6;   // row field
    localparam int PW   = 3;   // page field
    localparam int BW   = 8;   // stored byte
    localparam int ACCW = 10;  // signed remainder of the line stepper

    // Single set pixel, shifted into place by the row within a page.
    localparam logic [BW-1:0] PIX_BIT = 8'h01;

    typedef enum logic [1:0] {
        OP_POINT = 2'd0,
        OP_LINE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_DECODE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_BYTE_WAIT,
        ST_CLEAR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;       // capture the input transaction
        logic line_init;  // set up the line stepper
        logic line_step;  // advance to the next pixel of a line
        logic adj_step;   // move the row one step to settle the remainder
        logic pix_rd;     // read the byte holding the current pixel
        logic pix_wr;     // write that byte back with the pixel changed
        logic clr_wr;     // write zero at the clear counter and advance it
        logic byte_rd;    // read the byte addressed by a read command
        logic byte_cap;   // capture read data as the result
        logic push;       // move the result into the output register
    } t_cmd;

    typedef struct packed {
        t_op  op;         // captured command
        logic ok;         // command operands lie inside the store
        logic last;       // current pixel is the last of the line
        logic adj;        // row still needs an adjust step
        logic clr_last;   // clear counter is at the final address
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

### sv/mono_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine: page-packed monochrome framebuffer drawing
// Point, line, clear and byte readout on a COLUMNS x (PAGES*8) pixel store.
// ----------------------------------------------------------------------------
// Usage: each slave-side transaction carries one command in s_tuser (point,
// line, clear all, read byte) and its operands in s_tdata. Every command
// returns exactly one master-side transaction whose byte is the stored page
// byte for a read (LSB is the top row) and zero for all other commands.
// Operands outside the store make the command a no-op with a zero result.
// One command is worked on at a time; s_tready is high only while idle.
// Each pixel is a read-modify-write of the store, a read state followed
// by a write state; a sloped line adds one adjust step per row of rise to
// settle its exact rounding remainder, and a clear writes one byte per cycle.
// The block is back in idle at the edge where the result turns valid.
// After reset all COLUMNS*PAGES bytes of the store (1024 at the default
// size) are swept to zero with s_tready low. The result sits in an output
// register, so a stalled receiver delays only the return to idle; the next
// command is taken once that result has moved into the output register.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // start_x[6:0], start_y[12:7], end_x[19:13], end_y[25:20], pen_on[26],
    // page_sel[29:27], zero [31:30]
    input  logic [31:0] i_s_tdata,
    // command[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // read_byte[7:0]
    output logic [7:0]  o_m_tdata
);

    mfde_pkg::t_cmd cmd;
    mfde_pkg::t_sts sts;

    mfde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mfde_datapath #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (mfde_pkg::t_op'(i_s_tuser)),
        .i_start_x   (i_s_tdata[6:0]),
        .i_start_y   (i_s_tdata[12:7]),
        .i_end_x     (i_s_tdata[19:13]),
        .i_end_y     (i_s_tdata[25:20]),
        .i_pen_on    (i_s_tdata[26]),
        .i_page_sel  (i_s_tdata[29:27]),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_read_byte (o_m_tdata)
    );

endmodule

### sv/mfde_ram.sv
// ----------------------------------------------------------------------------
// mfde_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mfde_datapath.sv
// ----------------------------------------------------------------------------
// mfde_datapath: operand registers, line stepper, pixel store and result
// Executes the controller's commands against the packed pixel store.
// ----------------------------------------------------------------------------
module mfde_datapath #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mfde_pkg::t_cmd           i_cmd,
    output mfde_pkg::t_sts           o_sts,
    input  mfde_pkg::t_op            i_op,
    input  logic [mfde_pkg::XW-1:0]  i_start_x,
    input  logic [mfde_pkg::YW-1:0]  i_start_y,
    input  logic [mfde_pkg::XW-1:0]  i_end_x,
    input  logic [mfde_pkg::YW-1:0]  i_end_y,
    input  logic                     i_pen_on,
    input  logic [mfde_pkg::PW-1:0]  i_page_sel,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [mfde_pkg::BW-1:0]  o_read_byte
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROWS  = PAGES * 8;

    // Captured operands.
    mfde_pkg::t_op              r_op;
    logic [mfde_pkg::XW-1:0]    r_x1, r_x2;
    logic [mfde_pkg::YW-1:0]    r_y1, r_y2;
    logic [mfde_pkg::PW-1:0]    r_page;

    // Pixel position and line stepper.
    logic [mfde_pkg::XW-1:0]    r_px;
    logic [mfde_pkg::YW-1:0]    r_py;
    logic [mfde_pkg::XW-1:0]    r_cnt;
    logic signed [mfde_pkg::ACCW-1:0] r_acc;
    logic [mfde_pkg::XW:0]      r_n2;
    logic signed [mfde_pkg::YW+1:0]   r_dy2;
    logic                       r_step, r_xfwd, r_yfwd, r_set;

    // Clear counter, result and output register.
    logic [AW-1:0]              r_clr_addr;
    logic [mfde_pkg::BW-1:0]    r_result;
    logic                       r_out_valid;
    logic [mfde_pkg::BW-1:0]    r_out_byte;

    logic                       pt_ok, ln_ok, rd_ok, ok;
    logic                       x_fwd, y_fwd, vert;
    logic [mfde_pkg::XW-1:0]    dxa;
    logic [mfde_pkg::YW-1:0]    dya;
    logic signed [mfde_pkg::YW+1:0]   dy2;
    logic signed [mfde_pkg::ACCW-1:0] n2_s;
    logic                       adj;
    logic [AW-1:0]              pix_addr, byte_addr;
    logic [mfde_pkg::BW-1:0]    mask, rdata, wdata;
    logic                       we, re;
    logic [AW-1:0]              waddr, raddr;
    logic                       out_free;

    // Range checks on the captured operands.
    assign pt_ok = (int'(r_x1) < COLUMNS) && (int'(r_y1) < ROWS);
    assign ln_ok = pt_ok && (int'(r_x2) < COLUMNS) && (int'(r_y2) < ROWS);
    assign rd_ok = (int'(r_x1) < COLUMNS) && (int'(r_page) < PAGES);

    always_comb begin
        case (r_op)
            mfde_pkg::OP_POINT: ok = pt_ok;
            mfde_pkg::OP_LINE:  ok = ln_ok;
            mfde_pkg::OP_READ:  ok = rd_ok;
            default:            ok = 1'b1;
        endcase
    end

    // Line setup terms.
    assign x_fwd = r_x2 > r_x1;
    assign y_fwd = r_y2 > r_y1;
    assign vert  = r_x1 == r_x2;
    assign dxa   = x_fwd ? (r_x2 - r_x1) : (r_x1 - r_x2);
    assign dya   = y_fwd ? (r_y2 - r_y1) : (r_y1 - r_y2);
    assign dy2   = $signed({1'b0, r_y2, 1'b0}) - $signed({1'b0, r_y1, 1'b0});

    // The remainder must stay in [0, 2n) before a pixel is drawn.
    assign n2_s = $signed({{(mfde_pkg::ACCW - mfde_pkg::XW - 1){1'b0}}, r_n2});
    assign adj  = r_step && ((r_acc >= n2_s) || (r_acc < 0));

    assign pix_addr  = AW'(int'(r_px) * PAGES + int'(r_py[mfde_pkg::YW-1:3]));
    assign byte_addr = AW'(int'(r_x1) * PAGES + int'(r_page));
    assign mask      = mfde_pkg::PIX_BIT << r_py[2:0];

    always_comb begin
        if (i_cmd.clr_wr) begin
            wdata = '0;
        end else if (r_set) begin
            wdata = rdata | mask;
        end else begin
            wdata = rdata & ~mask;
        end
    end

    assign we    = i_cmd.clr_wr | i_cmd.pix_wr;
    assign waddr = i_cmd.clr_wr ? r_clr_addr : pix_addr;
    assign re    = i_cmd.pix_rd | i_cmd.byte_rd;
    assign raddr = i_cmd.byte_rd ? byte_addr : pix_addr;

    mfde_ram #(
        .WIDTH (mfde_pkg::BW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Operand capture and line stepper.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_x1   <= i_start_x;
            r_y1   <= i_start_y;
            r_x2   <= i_end_x;
            r_y2   <= i_end_y;
            r_page <= i_page_sel;
            r_px   <= i_start_x;
            r_py   <= i_start_y;
            r_set  <= i_pen_on;
            r_step <= 1'b0;
        end else if (i_cmd.line_init) begin
            r_px   <= r_x1;
            r_py   <= r_y1;
            r_set  <= 1'b1;
            r_step <= !vert;
            r_cnt  <= vert ? {1'b0, dya} : dxa;
            r_acc  <= $signed({{(mfde_pkg::ACCW - mfde_pkg::XW){1'b0}}, dxa});
            r_n2   <= {dxa, 1'b0};
            r_dy2  <= dy2;
            r_xfwd <= x_fwd;
            r_yfwd <= y_fwd;
        end else if (i_cmd.line_step) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_step) begin
                r_px  <= r_xfwd ? (r_px + 1'b1) : (r_px - 1'b1);
                r_acc <= r_acc + {{(mfde_pkg::ACCW - mfde_pkg::YW - 2){r_dy2[mfde_pkg::YW+1]}},
                                  r_dy2};
            end else begin
                r_py <= r_yfwd ? (r_py + 1'b1) : (r_py - 1'b1);
            end
        end else if (i_cmd.adj_step) begin
            if (r_acc >= n2_s) begin
                r_acc <= r_acc - n2_s;
                r_py  <= r_py + 1'b1;
            end else begin
                r_acc <= r_acc + n2_s;
                r_py  <= r_py - 1'b1;
            end
        end
    end

    // Result byte: zero unless a read command captures the store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_result <= '0;
        end else if (i_cmd.byte_cap) begin
            r_result <= rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_addr <= '0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Output register parts the result from the draw work.
    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_byte <= r_result;
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_read_byte = r_out_byte;

    assign o_sts.op       = r_op;
    assign o_sts.ok       = ok;
    assign o_sts.last     = r_cnt == '0;
    assign o_sts.adj      = adj;
    assign o_sts.clr_last = r_clr_addr == AW'(DEPTH - 1);
    assign o_sts.out_free = out_free;

    // A pixel written back always lies inside the store.
    a_pix_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pix_wr |-> (int'(r_px) < COLUMNS) && (int'(r_py) < ROWS))
        else $error("pixel write outside the store");

    // The row is settled (remainder in range) whenever a pixel of a sloped or horizontal line is read.
    a_row_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pix_rd && r_step) |-> (r_acc >= 0) && (r_acc < n2_s))
        else $error("line pixel drawn with unsettled remainder");

    // A result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!r_out_valid || i_m_tready))
        else $error("result pushed over a pending result");

endmodule

### sv/mfde_ctrl.sv
// ----------------------------------------------------------------------------
// mfde_ctrl: command sequencer of the framebuffer draw engine
// Steps each command through decode, pixel read-modify-write, byte read,
// clear sweep and result delivery, after the store is wiped at reset.
// ----------------------------------------------------------------------------
module mfde_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  mfde_pkg::t_sts  i_sts,
    output mfde_pkg::t_cmd  o_cmd
);

    mfde_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfde_pkg::ST_WIPE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mfde_pkg::ST_WIPE: begin
                if (i_sts.clr_last) n_state = mfde_pkg::ST_IDLE;
            end
            mfde_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = mfde_pkg::ST_DECODE;
            end
            mfde_pkg::ST_DECODE: begin
                case (i_sts.op)
                    mfde_pkg::OP_CLEAR: n_state = mfde_pkg::ST_CLEAR;
                    mfde_pkg::OP_READ:
                        n_state = i_sts.ok ? mfde_pkg::ST_BYTE_WAIT : mfde_pkg::ST_DONE;
                    default:
                        n_state = i_sts.ok ? mfde_pkg::ST_PIX_RD : mfde_pkg::ST_DONE;
                endcase
            end
            mfde_pkg::ST_PIX_RD: begin
                if (!i_sts.adj) n_state = mfde_pkg::ST_PIX_WR;
            end
            mfde_pkg::ST_PIX_WR: begin
                if (i_sts.op == mfde_pkg::OP_POINT || i_sts.last) begin
                    n_state = mfde_pkg::ST_DONE;
                end else begin
                    n_state = mfde_pkg::ST_PIX_RD;
                end
            end
            mfde_pkg::ST_BYTE_WAIT: begin
                n_state = mfde_pkg::ST_DONE;
            end
            mfde_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = mfde_pkg::ST_DONE;
            end
            mfde_pkg::ST_DONE: begin
                if (i_sts.out_free) n_state = mfde_pkg::ST_IDLE;
            end
            default: begin
                n_state = mfde_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            mfde_pkg::ST_WIPE, mfde_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            mfde_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            mfde_pkg::ST_DECODE: begin
                o_cmd.line_init = (i_sts.op == mfde_pkg::OP_LINE);
                o_cmd.byte_rd   = (i_sts.op == mfde_pkg::OP_READ) && i_sts.ok;
            end
            mfde_pkg::ST_PIX_RD: begin
                o_cmd.adj_step = i_sts.adj;
                o_cmd.pix_rd   = !i_sts.adj;
            end
            mfde_pkg::ST_PIX_WR: begin
                o_cmd.pix_wr    = 1'b1;
                o_cmd.line_step = (i_sts.op == mfde_pkg::OP_LINE) && !i_sts.last;
            end
            mfde_pkg::ST_BYTE_WAIT: begin
                o_cmd.byte_cap = 1'b1;
            end
            mfde_pkg::ST_DONE: begin
                o_cmd.push = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
